// ===== design/bsg_pkg.sv =====
// Types, codes and defaults shared by the banker safe grant block.
`default_nettype none
package bsg_pkg;

    localparam int BSG_MAX_PROCS = 8;
    localparam int BSG_UNIT_BITS = 16;
    localparam int BSG_RES_COUNT = 3;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_AVAIL   = 2'd1;
    localparam logic [1:0] REQ_REQUEST = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [2:0] ST_EXCEED_AVAIL = 3'd0;
    localparam logic [2:0] ST_EXCEED_NEED  = 3'd1;
    localparam logic [2:0] ST_UNSAFE       = 3'd2;
    localparam logic [2:0] ST_GRANTED      = 3'd3;
    localparam logic [2:0] ST_LOADED       = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  process_index;
        logic [15:0] amount_r1;
        logic [15:0] amount_r2;
        logic [15:0] amount_r3;
        logic [15:0] need_r1;
        logic [15:0] need_r2;
        logic [15:0] need_r3;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] seq_process;
        logic       last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN,
        S_ROLL,
        S_REPLY,
        S_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== design/bsg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ===== design/banker_safe_grant.sv =====
// Top level of the banker safe grant block: sequencer, state memories and result register.
//
// A load or available-vector write passes through the decode and reply states, and its
// result word is registered in the reply state. A request reads the process entry and
// checks it; one that fits updates the entry and then searches for the safe order:
// each sequence position rescans the process table from index 0 through the memory
// read port, one entry a cycle. A granted request then sends one result word per
// checked process in sequence order; an unsafe request passes through a rollback
// state and sends one reply word instead, as does a request that does not fit. The
// allocation and need tables live in two RAMs sharing one address; entries never
// loaded read as zero through per-entry valid bits. One item is handled at a time.
`default_nettype none
module banker_safe_grant #(
    parameter int MAX_PROCS = bsg_pkg::BSG_MAX_PROCS,
    parameter int UNIT_BITS = bsg_pkg::BSG_UNIT_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bsg_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bsg_pkg::out_word_t     out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [3:0]        cfg_wr_data
);

    import bsg_pkg::*;

    localparam int UW = UNIT_BITS;
    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int WW = UW + CW;
    localparam int RW = BSG_RES_COUNT * UW;
    localparam logic [UW-1:0] UNIT_MAX = {UW{1'b1}};

    typedef logic [UW-1:0] unit_t;
    typedef logic [WW-1:0] wide_t;

    state_t state_reg, state_next;

    in_word_t item_reg;
    logic [3:0] pcount_reg;
    logic [CW-1:0] count;

    unit_t avail_reg [BSG_RES_COUNT];
    unit_t avail_next [BSG_RES_COUNT];
    unit_t save_avail_reg [BSG_RES_COUNT];
    logic [RW-1:0] save_alloc_reg, save_need_reg;
    wide_t work_reg [BSG_RES_COUNT];
    wide_t work_next [BSG_RES_COUNT];

    logic [MAX_PROCS-1:0] vld_reg, done_reg, done_next;
    logic vld_rd_reg;

    logic [AW-1:0] order_reg [MAX_PROCS];
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [AW-1:0] eval_idx_reg, eval_idx_next;
    logic rd_valid_reg, rd_valid_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;
    logic [2:0] status_reg, status_next;

    logic [AW-1:0] ram_addr;
    logic ram_we;
    logic [RW-1:0] alloc_wdata, need_wdata, alloc_rdata, need_rdata;
    logic [RW-1:0] alloc_eff, need_eff;

    out_word_t out_reg, out_next;
    logic out_valid_reg, out_load, out_free;

    logic accept;
    logic p_in_range;
    logic [AW-1:0] p_addr;
    unit_t amt [BSG_RES_COUNT];
    unit_t ldn [BSG_RES_COUNT];

    logic fit_avail, fit_need, need_zero;
    logic [RW-1:0] alloc_upd, need_upd;
    unit_t avail_sub [BSG_RES_COUNT];
    unit_t alloc_sat [BSG_RES_COUNT];
    unit_t need_sub [BSG_RES_COUNT];

    logic found, unsafe, scan_last;

    function automatic unit_t sat_add(unit_t a, unit_t b);
        logic [UW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[UW] ? UNIT_MAX : s[UW-1:0];
    endfunction

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (pcount_reg == 4'd0)
        begin
            count = CW'(1);
        end
        else if (32'(pcount_reg) > MAX_PROCS)
        begin
            count = CW'(MAX_PROCS);
        end
        else
        begin
            count = CW'(pcount_reg);
        end
    end

    assign p_in_range = (32'(item_reg.process_index) < MAX_PROCS);
    assign p_addr = AW'(item_reg.process_index);
    assign amt[0] = UW'(item_reg.amount_r1);
    assign amt[1] = UW'(item_reg.amount_r2);
    assign amt[2] = UW'(item_reg.amount_r3);
    assign ldn[0] = UW'(item_reg.need_r1);
    assign ldn[1] = UW'(item_reg.need_r2);
    assign ldn[2] = UW'(item_reg.need_r3);

    assign alloc_eff = vld_rd_reg ? alloc_rdata : '0;
    assign need_eff = vld_rd_reg ? need_rdata : '0;

    // Tentative grant arithmetic on the entry read for the requester
    always_comb
    begin
        fit_avail = 1'b1;
        fit_need = 1'b1;
        need_zero = 1'b1;
        for (int r = 0; r < BSG_RES_COUNT; r++)
        begin
            fit_avail = fit_avail && (amt[r] <= avail_reg[r]);
            fit_need = fit_need && (amt[r] <= need_eff[r*UW +: UW]);
            avail_sub[r] = avail_reg[r] - amt[r];
            alloc_sat[r] = sat_add(alloc_eff[r*UW +: UW], amt[r]);
            need_sub[r] = need_eff[r*UW +: UW] - amt[r];
            need_zero = need_zero && (need_sub[r] == '0);
        end
        for (int r = 0; r < BSG_RES_COUNT; r++)
        begin
            need_upd[r*UW +: UW] = need_sub[r];
            alloc_upd[r*UW +: UW] = need_zero ? '0 : alloc_sat[r];
        end
    end

    // Safety scan evaluation of the entry read last cycle
    always_comb
    begin
        logic fit;
        fit = 1'b1;
        for (int r = 0; r < BSG_RES_COUNT; r++)
        begin
            fit = fit && (WW'(need_eff[r*UW +: UW]) <= work_reg[r]);
        end
        found = rd_valid_reg && !done_reg[eval_idx_reg] && fit;
        scan_last = (CW'(eval_idx_reg) == count - CW'(1));
        unsafe = rd_valid_reg && !found && scan_last;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (item_reg.req_type)
                    REQ_LOAD, REQ_AVAIL: state_next = S_REPLY;
                    REQ_REQUEST:         state_next = S_CHECK;
                    default:             state_next = S_IDLE;
                endcase
            end
            S_CHECK:
            begin
                if (!fit_avail || !p_in_range || !fit_need)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (found && (pos_reg + CW'(1) == count))
                begin
                    state_next = S_EMIT;
                end
                else if (unsafe)
                begin
                    state_next = S_ROLL;
                end
            end
            S_ROLL:
            begin
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free && (emit_idx_reg + CW'(1) == count))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath controls
    always_comb
    begin
        ram_addr = p_addr;
        ram_we = 1'b0;
        alloc_wdata = alloc_upd;
        need_wdata = need_upd;
        avail_next = avail_reg;
        work_next = work_reg;
        done_next = done_reg;
        pos_next = pos_reg;
        scan_idx_next = scan_idx_reg;
        eval_idx_next = eval_idx_reg;
        rd_valid_next = 1'b0;
        emit_idx_next = emit_idx_reg;
        status_next = status_reg;
        out_load = 1'b0;
        out_next = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_addr = p_addr;
            end
            S_DECODE:
            begin
                status_next = ST_LOADED;
                if (item_reg.req_type == REQ_LOAD)
                begin
                    ram_we = p_in_range;
                    for (int r = 0; r < BSG_RES_COUNT; r++)
                    begin
                        alloc_wdata[r*UW +: UW] = amt[r];
                        need_wdata[r*UW +: UW] = ldn[r];
                    end
                end
                else if (item_reg.req_type == REQ_AVAIL)
                begin
                    for (int r = 0; r < BSG_RES_COUNT; r++)
                    begin
                        avail_next[r] = amt[r];
                    end
                end
            end
            S_CHECK:
            begin
                if (!fit_avail)
                begin
                    status_next = ST_EXCEED_AVAIL;
                end
                else if (!p_in_range || !fit_need)
                begin
                    status_next = ST_EXCEED_NEED;
                end
                else
                begin
                    ram_we = 1'b1;
                    for (int r = 0; r < BSG_RES_COUNT; r++)
                    begin
                        avail_next[r] = need_zero ? sat_add(avail_sub[r], alloc_sat[r])
                                                  : avail_sub[r];
                        work_next[r] = WW'(avail_next[r]);
                    end
                    done_next = '0;
                    pos_next = '0;
                    scan_idx_next = '0;
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    done_next[eval_idx_reg] = 1'b1;
                    pos_next = pos_reg + CW'(1);
                    for (int r = 0; r < BSG_RES_COUNT; r++)
                    begin
                        work_next[r] = work_reg[r] + WW'(alloc_eff[r*UW +: UW]);
                    end
                    // restart the scan from the lowest index
                    ram_addr = '0;
                    rd_valid_next = 1'b1;
                    eval_idx_next = '0;
                    scan_idx_next = CW'(1);
                    emit_idx_next = '0;
                end
                else if (!unsafe && (scan_idx_reg < count))
                begin
                    ram_addr = scan_idx_reg[AW-1:0];
                    rd_valid_next = 1'b1;
                    eval_idx_next = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                status_next = ST_UNSAFE;
            end
            S_ROLL:
            begin
                ram_we = 1'b1;
                alloc_wdata = save_alloc_reg;
                need_wdata = save_need_reg;
                for (int r = 0; r < BSG_RES_COUNT; r++)
                begin
                    avail_next[r] = save_avail_reg[r];
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next.status = status_reg;
                    out_next.seq_process = '0;
                    out_next.last = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next.status = ST_GRANTED;
                    out_next.seq_process = 3'(order_reg[emit_idx_reg[AW-1:0]]);
                    out_next.last = (emit_idx_reg + CW'(1) == count);
                    emit_idx_next = emit_idx_reg + CW'(1);
                end
            end
            default:
            begin
                ram_addr = p_addr;
            end
        endcase
    end

    bsg_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_PROCS)
    ) u_alloc_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(alloc_wdata),
        .raddr(ram_addr),
        .rdata(alloc_rdata)
    );

    bsg_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_PROCS)
    ) u_need_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(need_wdata),
        .raddr(ram_addr),
        .rdata(need_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pcount_reg <= 4'd8;
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            for (int r = 0; r < BSG_RES_COUNT; r++)
            begin
                avail_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rd_valid_reg <= rd_valid_next;
            avail_reg <= avail_next;
            if (cfg_wr_en)
            begin
                pcount_reg <= cfg_wr_data;
            end
            if (ram_we)
            begin
                vld_reg[ram_addr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if ((state_reg == S_SCAN) && found)
        begin
            order_reg[pos_reg[AW-1:0]] <= eval_idx_reg;
        end
        // hold the pre-grant state for a rollback
        if (state_reg == S_CHECK)
        begin
            save_avail_reg <= avail_reg;
            save_alloc_reg <= alloc_eff;
            save_need_reg <= need_eff;
        end
        vld_rd_reg <= vld_reg[ram_addr];
        work_reg <= work_next;
        done_reg <= done_next;
        pos_reg <= pos_next;
        scan_idx_reg <= scan_idx_next;
        eval_idx_reg <= eval_idx_next;
        emit_idx_reg <= emit_idx_next;
        status_reg <= status_next;
    end

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DECODE))
        else $error("accepted word not decoded");

    a_not_granted_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != ST_GRANTED)) |-> out_reg.last)
        else $error("refusal word without last");

    a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (pos_reg < count))
        else $error("scan position out of range");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_idx_reg < count))
        else $error("emit index out of range");

endmodule
`default_nettype wire
